@@ rtl/core/ael_pkg.sv @@
// Shared types, constants and the operator table for the expression lexer.
// No dependencies; every other file of the block imports this package.
package ael_pkg;

	localparam int VALUE_BITS  = 31;
	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int OP_BITS     = 3;
	localparam int BIND_BITS   = 3;
	localparam int CHAR_BITS   = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_TDATA_W  = ((CHAR_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = VALUE_BITS + OP_BITS + 2 * BIND_BITS + CHAR_BITS
		+ LINE_BITS + COLUMN_BITS;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

	localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_OPEN   = 8'h28;
	localparam logic [CHAR_BITS-1:0] CH_CLOSE  = 8'h29;
	localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_CARET  = 8'h5E;

	typedef enum logic [2:0] {
		TK_END   = 3'd0,
		TK_INT   = 3'd1,
		TK_OPER  = 3'd2,
		TK_OPEN  = 3'd3,
		TK_CLOSE = 3'd4,
		TK_ERR   = 3'd5
	} tok_kind_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_MUL = 3'd0,
		OP_DIV = 3'd1,
		OP_ADD = 3'd2,
		OP_SUB = 3'd3,
		OP_POW = 3'd4
	} op_code_t;

	typedef struct packed {
		logic                  hit;
		op_code_t              code;
		logic [BIND_BITS-1:0]  bind_l;
		logic [BIND_BITS-1:0]  bind_r;
	} op_info_t;

	// one queue entry: an optional pending integer followed by an optional token
	typedef struct packed {
		logic                   num_vld;
		logic [VALUE_BITS-1:0]  num_value;
		logic                   tok_vld;
		tok_kind_t              tok_kind;
		op_code_t               op_code;
		logic [BIND_BITS-1:0]   bind_l;
		logic [BIND_BITS-1:0]   bind_r;
		logic [CHAR_BITS-1:0]   bad_char;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
	} rec_t;

	function automatic op_info_t op_lookup(input logic [CHAR_BITS-1:0] c);
		op_info_t r;
		r = '0;
		case (c)
			CH_STAR:  r = '{hit: 1'b1, code: OP_MUL, bind_l: 3'd3, bind_r: 3'd4};
			CH_SLASH: r = '{hit: 1'b1, code: OP_DIV, bind_l: 3'd3, bind_r: 3'd4};
			CH_PLUS:  r = '{hit: 1'b1, code: OP_ADD, bind_l: 3'd1, bind_r: 3'd2};
			CH_MINUS: r = '{hit: 1'b1, code: OP_SUB, bind_l: 3'd1, bind_r: 3'd2};
			CH_CARET: r = '{hit: 1'b1, code: OP_POW, bind_l: 3'd5, bind_r: 3'd6};
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/ael_front.sv @@
// Front end: accepts characters, tracks position, number and error state,
// and builds queue entries of up to two tokens. Depends on ael_pkg.
module ael_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ael_pkg::IN_TDATA_W-1:0] s_tdata, // char_code
	input  logic                          s_tlast,  // end_of_input
	input  logic                          q_full,
	output logic                          q_push,
	output ael_pkg::rec_t                 q_rec
);
	import ael_pkg::*;

	localparam int PROD_W = VALUE_BITS + 4;

	logic                   num_active_q;
	logic [VALUE_BITS-1:0]  num_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic                   err_q;

	logic [CHAR_BITS-1:0]   c;
	logic                   accept;
	logic                   is_end;
	logic                   is_digit;
	logic                   is_space;
	logic [3:0]             digit;
	logic [PROD_W-1:0]      prod;
	logic [VALUE_BITS-1:0]  num_nxt;
	logic [LINE_BITS-1:0]   line_nxt;
	logic [COLUMN_BITS-1:0] col_nxt;
	op_info_t               op;
	rec_t                   rec;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		c        = s_tdata[CHAR_BITS-1:0];
		is_end   = s_tlast || (c == CH_NUL);
		is_digit = c inside {[CH_ZERO:CH_NINE]};
		is_space = c inside {CH_SPACE, CH_TAB, CH_NL};
		digit    = 4'(c - CH_ZERO);
		op       = op_lookup(c);

		prod = PROD_W'({num_q, 3'b000}) + PROD_W'({num_q, 1'b0}) + PROD_W'(digit);
		if (!num_active_q) begin
			num_nxt = VALUE_BITS'(digit);
		end else if (prod > PROD_W'(VALUE_MAX)) begin
			num_nxt = VALUE_MAX;
		end else begin
			num_nxt = prod[VALUE_BITS-1:0];
		end

		line_nxt = line_q;
		col_nxt  = col_q;
		if (c == CH_NL) begin
			if (line_q != LINE_MAX) begin
				line_nxt = line_q + 1'b1;
			end
			col_nxt = COLUMN_BITS'(1);
		end else if (col_q != COLUMN_MAX) begin
			col_nxt = col_q + 1'b1;
		end

		rec = '0;
		if (is_end) begin
			rec.num_vld   = num_active_q && !err_q;
			rec.num_value = num_q;
			rec.tok_vld   = 1'b1;
			rec.tok_kind  = TK_END;
		end else if (!err_q && !is_digit) begin
			rec.num_vld   = num_active_q;
			rec.num_value = num_q;
			if (!is_space) begin
				rec.tok_vld = 1'b1;
				if (c == CH_OPEN) begin
					rec.tok_kind = TK_OPEN;
				end else if (c == CH_CLOSE) begin
					rec.tok_kind = TK_CLOSE;
				end else if (op.hit) begin
					rec.tok_kind = TK_OPER;
					rec.op_code  = op.code;
					rec.bind_l   = op.bind_l;
					rec.bind_r   = op.bind_r;
				end else begin
					rec.tok_kind = TK_ERR;
					rec.bad_char = c;
					rec.line     = line_nxt;
					rec.col      = col_nxt;
				end
			end
		end
	end

	assign q_rec  = rec;
	assign q_push = accept && (rec.num_vld || rec.tok_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_active_q <= 1'b0;
			num_q        <= '0;
			line_q       <= LINE_BITS'(1);
			col_q        <= '0;
			err_q        <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				num_active_q <= 1'b0;
				num_q        <= '0;
				line_q       <= LINE_BITS'(1);
				col_q        <= '0;
				err_q        <= 1'b0;
			end else if (!err_q) begin
				line_q <= line_nxt;
				col_q  <= col_nxt;
				if (is_digit) begin
					num_active_q <= 1'b1;
					num_q        <= num_nxt;
				end else begin
					num_active_q <= 1'b0;
					num_q        <= '0;
					if (rec.tok_vld && rec.tok_kind == TK_ERR) begin
						err_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/ael_queue.sv @@
// Short queue of token entries between front and back end.
// Depends on ael_pkg for the entry type and depth.
module ael_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ael_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ael_pkg::rec_t head
);
	import ael_pkg::*;

	rec_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/ael_back.sv @@
// Back end: splits each queue entry into output words and holds the
// output register. Depends on ael_pkg.
module ael_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  ael_pkg::rec_t                   q_head,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ael_pkg::OUT_TDATA_W-1:0] m_tdata, // int_value, op_code, bind_left,
	                                                 // bind_right, bad_char, err_line,
	                                                 // err_column
	output logic [2:0]                      m_tuser, // token_kind
	output logic                            m_tlast  // last
);
	import ael_pkg::*;

	logic                    phase_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [2:0]              m_tuser_q;
	logic                    m_tlast_q;

	logic                    load;
	logic                    int_word;
	logic [OUT_FIELDS_W-1:0] fields;
	tok_kind_t               kind;
	logic                    last;

	assign load     = !q_empty && (!m_tvalid_q || m_tready);
	assign int_word = !phase_q && q_head.num_vld;
	assign q_pop    = load && (!int_word || !q_head.tok_vld);

	always_comb begin
		if (int_word) begin
			kind   = TK_INT;
			last   = !q_head.tok_vld;
			fields = OUT_FIELDS_W'(q_head.num_value);
		end else begin
			kind   = q_head.tok_kind;
			last   = 1'b1;
			fields = {q_head.col, q_head.line, q_head.bad_char, q_head.bind_r,
				q_head.bind_l, q_head.op_code, {VALUE_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				phase_q    <= int_word && q_head.tok_vld;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= OUT_TDATA_W'(fields);
			m_tuser_q <= kind;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ rtl/core/arithmetic_expression_lexer.sv @@
// Arithmetic expression lexer: one character word in, zero to two token words out.
// A token word passes through a queue entry and then the output register.
// Throughput: one character per cycle while the queue is not full; the four-entry
// token queue absorbs the bursts of characters that yield two token words each.
// Reset (arst_n low) clears position, number and error state and empties the queue.
// Depends on ael_pkg, ael_front, ael_queue and ael_back.
module arithmetic_expression_lexer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ael_pkg::IN_TDATA_W-1:0]  s_tdata, // char_code
	input  logic                            s_tlast, // end_of_input
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ael_pkg::OUT_TDATA_W-1:0] m_tdata, // int_value, op_code, bind_left,
	                                                 // bind_right, bad_char, err_line,
	                                                 // err_column
	output logic [2:0]                      m_tuser, // token_kind
	output logic                            m_tlast  // last
);
	import ael_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	rec_t q_rec;
	rec_t q_head;

	ael_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (q_rec)
	);

	ael_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	ael_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sim/arithmetic_expression_lexer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for arithmetic_expression_lexer: directed and random
// character streams, with a token predictor and scoreboard. Depends on ael_pkg.
module arithmetic_expression_lexer_tb;
	import ael_pkg::*;

	localparam int OP_LSB   = VALUE_BITS;
	localparam int BL_LSB   = OP_LSB + OP_BITS;
	localparam int BR_LSB   = BL_LSB + BIND_BITS;
	localparam int BAD_LSB  = BR_LSB + BIND_BITS;
	localparam int LINE_LSB = BAD_LSB + CHAR_BITS;
	localparam int COL_LSB  = LINE_LSB + LINE_BITS;

	typedef struct {
		tok_kind_t              kind;
		logic [VALUE_BITS-1:0]  value;
		logic [OP_BITS-1:0]     op;
		logic [BIND_BITS-1:0]   bind_l;
		logic [BIND_BITS-1:0]   bind_r;
		logic [CHAR_BITS-1:0]   bad;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic                   last;
	} token_t;

	class token_scoreboard;
		token_t                 tokens_due[$];
		int                     errors;
		bit                     num_on;
		logic [VALUE_BITS-1:0]  num_val;
		logic [LINE_BITS-1:0]   line_no;
		logic [COLUMN_BITS-1:0] col_no;
		bit                     err_held;

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			num_on = 1'b0;
			num_val = '0;
			line_no = LINE_BITS'(1);
			col_no = '0;
			err_held = 1'b0;
		endfunction

		function void push_token(tok_kind_t k, logic [VALUE_BITS-1:0] v, op_code_t op,
				int bl, int br, logic [CHAR_BITS-1:0] bad, logic [LINE_BITS-1:0] ln,
				logic [COLUMN_BITS-1:0] cl);
			token_t t;
			t.kind = k;
			t.value = v;
			t.op = op;
			t.bind_l = BIND_BITS'(bl);
			t.bind_r = BIND_BITS'(br);
			t.bad = bad;
			t.line = ln;
			t.col = cl;
			t.last = 1'b0;
			tokens_due.push_back(t);
		endfunction

		// returns 1 when the word was not merely dropped behind a latched error
		function int note_char(logic [CHAR_BITS-1:0] c, logic eoi);
			int         n0;
			logic [3:0] d;
			n0 = tokens_due.size();
			if (eoi || c == CH_NUL) begin
				if (num_on && !err_held)
					push_token(TK_INT, num_val, OP_MUL, 0, 0, '0, '0, '0);
				push_token(TK_END, '0, OP_MUL, 0, 0, '0, '0, '0);
				tokens_due[tokens_due.size()-1].last = 1'b1;
				clear_state();
				return 1;
			end
			if (err_held)
				return 0;
			if (c == CH_NL) begin
				if (line_no != LINE_MAX)
					line_no++;
				col_no = COLUMN_BITS'(1);
			end else if (col_no != COLUMN_MAX) begin
				col_no++;
			end
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = 4'(c - CH_ZERO);
				if (!num_on) begin
					num_on = 1'b1;
					num_val = VALUE_BITS'(d);
				end else if (longint'(num_val) * 10 + longint'(d) > longint'(VALUE_MAX)) begin
					num_val = VALUE_MAX;
				end else begin
					num_val = VALUE_BITS'(longint'(num_val) * 10 + longint'(d));
				end
				return 1;
			end
			if (num_on) begin
				push_token(TK_INT, num_val, OP_MUL, 0, 0, '0, '0, '0);
				num_on = 1'b0;
				num_val = '0;
			end
			case (c)
				CH_SPACE, CH_TAB, CH_NL: ;
				CH_OPEN:  push_token(TK_OPEN, '0, OP_MUL, 0, 0, '0, '0, '0);
				CH_CLOSE: push_token(TK_CLOSE, '0, OP_MUL, 0, 0, '0, '0, '0);
				CH_STAR:  push_token(TK_OPER, '0, OP_MUL, 3, 4, '0, '0, '0);
				CH_SLASH: push_token(TK_OPER, '0, OP_DIV, 3, 4, '0, '0, '0);
				CH_PLUS:  push_token(TK_OPER, '0, OP_ADD, 1, 2, '0, '0, '0);
				CH_MINUS: push_token(TK_OPER, '0, OP_SUB, 1, 2, '0, '0, '0);
				CH_CARET: push_token(TK_OPER, '0, OP_POW, 5, 6, '0, '0, '0);
				default: begin
					push_token(TK_ERR, '0, OP_MUL, 0, 0, c, line_no, col_no);
					err_held = 1'b1;
				end
			endcase
			if (tokens_due.size() > n0)
				tokens_due[tokens_due.size()-1].last = 1'b1;
			return 1;
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_token(logic [2:0] kind, logic [OUT_TDATA_W-1:0] d, logic lst);
			token_t t;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token expected none actual kind %0d data %h",
					$time, kind, d);
				errors++;
				return;
			end
			t = tokens_due.pop_front();
			compare("token_kind", t.kind, kind);
			compare("int_value", t.value, d[OP_LSB-1:0]);
			compare("op_code", t.op, d[BL_LSB-1:OP_LSB]);
			compare("bind_left", t.bind_l, d[BR_LSB-1:BL_LSB]);
			compare("bind_right", t.bind_r, d[BAD_LSB-1:BR_LSB]);
			compare("bad_char", t.bad, d[LINE_LSB-1:BAD_LSB]);
			compare("err_line", t.line, d[COL_LSB-1:LINE_LSB]);
			compare("err_column", t.col, d[COL_LSB+COLUMN_BITS-1:COL_LSB]);
			compare("last", t.last, lst);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]             m_tuser;
	logic                   m_tlast;

	token_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              counted = 0;
	int              stall_left = 0;
	logic [7:0]      op_chars[5] = '{CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_CARET};

	arithmetic_expression_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_token(m_tuser, m_tdata, m_tlast);
	end

	task automatic send_char(input logic [7:0] c, input logic eoi);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eoi;
		do @(posedge clk); while (!s_tready);
		counted += sb.note_char(c, eoi);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic send_number();
		int len;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
		repeat (len) send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
	endtask

	task automatic send_expression();
		int         terms;
		logic [7:0] c;
		terms = $urandom_range(1, 8);
		for (int i = 0; i < terms; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0: send_char(CH_SPACE, 1'b0);
					1: send_char(CH_TAB, 1'b0);
					default: send_char(CH_NL, 1'b0);
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				send_char(CH_OPEN, 1'b0);
			send_number();
			if ($urandom_range(0, 24) == 0) begin
				do c = 8'($urandom_range(1, 255));
				while (c inside {[CH_ZERO:CH_NINE], CH_SPACE, CH_TAB, CH_NL, CH_OPEN,
					CH_CLOSE, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_CARET});
				send_char(c, 1'b0);
			end
			if ($urandom_range(0, 4) == 0)
				send_char(CH_CLOSE, 1'b0);
			if (i != terms - 1)
				send_char(op_chars[3'($urandom_range(0, 4))], 1'b0);
		end
		if ($urandom_range(0, 1) == 0)
			send_char(8'($urandom_range(0, 255)), 1'b1);
		else
			send_char(CH_NUL, 1'b0);
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, parens, whitespace, end by tlast with a pending number
		send_text("(9+0)*1/2-3^4\t\n 8");
		send_char("x", 1'b1);
		// saturated number flushed by an error, dropped digit, end by zero byte
		send_text("9999999999");
		send_char(8'hFF, 1'b0);
		send_char("5", 1'b0);
		send_char(CH_NUL, 1'b0);

		counted = 0;
		while (counted < 1750) begin
			if (counted >= 1550)
				quiet = 1'b1;
			if ($urandom_range(0, 6) != 0)
				send_expression();
			else
				repeat ($urandom_range(1, 8))
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
		end
		send_char(CH_NUL, 1'b0);
		s_tvalid <= 1'b0;

		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("arithmetic_expression_lexer_tb passed");
		else
			$display("arithmetic_expression_lexer_tb failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("arithmetic_expression_lexer_tb failed");
		$finish;
	end

endmodule
